// File: src/avr_pkg.sv
// Shared constants and helpers for the axis vector rotation block.
// Holds the CORDIC angle table, the command codes and the internal datapath widths.
// No dependencies.
package avr_pkg;

    // rotation axis codes carried in the request's command field
    localparam logic [1:0] CMD_ROT_X = 2'd0;
    localparam logic [1:0] CMD_ROT_Y = 2'd1;
    localparam logic [1:0] CMD_ROT_Z = 2'd2;
    localparam logic [1:0] CMD_PASS  = 2'd3;

    // CORDIC setup: binary angle of 32 bits, vectors in Q4.30
    localparam int unsigned CORDIC_STEPS    = 30;
    localparam int unsigned TURN_W          = 32;
    localparam int unsigned XY_W            = 34;
    localparam int unsigned Z_W             = 34;
    localparam int unsigned COEF_W          = 32;
    localparam int unsigned FRAC_BITS       = 30;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

    typedef logic signed [XY_W-1:0]   t_xy;
    typedef logic signed [Z_W-1:0]    t_ang;
    typedef logic signed [COEF_W-1:0] t_coef;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn32(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            24:      v = 32'd41;
            25:      v = 32'd20;
            26:      v = 32'd10;
            27:      v = 32'd5;
            28:      v = 32'd3;
            29:      v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/avr_intf.sv
// Valid/ready channel interfaces for the axis vector rotation block.
// avr_vtx_if carries vertex requests, avr_rot_if carries rotated vertices.
// No dependencies.
interface avr_vtx_if #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic [1:0]                     command;
    logic signed [COORD_WIDTH-1:0]  x;
    logic signed [COORD_WIDTH-1:0]  y;
    logic signed [COORD_WIDTH-1:0]  z;
    logic [ANGLE_WIDTH-1:0]         angle;

    modport source (output valid, command, x, y, z, angle, input ready);
    modport sink   (input valid, command, x, y, z, angle, output ready);
endinterface

interface avr_rot_if #(
    parameter int COORD_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [COORD_WIDTH-1:0]  out_x;
    logic signed [COORD_WIDTH-1:0]  out_y;
    logic signed [COORD_WIDTH-1:0]  out_z;

    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

// File: src/axis_vector_rotation.sv
// Top level of the axis vector rotation block: pipelined CORDIC and rotation datapath.
// Depends on avr_pkg and the channel interfaces in avr_intf.sv.
//
// Rotates one Q16.16 vertex per request about X, Y or Z by a binary angle
// (one turn = 2^ANGLE_WIDTH); command 3 passes the vertex through. The block
// accepts one request per clock while the output side does not stall, and
// each request passes through 36 register stages: one input stage, thirty
// CORDIC stages (one micro-rotation each), then coefficient, partial-product,
// partial sum, rounding and saturation stages. Sustained rate without stalls
// is one vertex per cycle, set by the CORDIC stage chain and the split
// multiplier stage. Backpressure freezes the whole pipeline; i_vtx.ready
// drops only while a finished result waits at the output and o_rot.ready is
// low. There is no state across requests.
module axis_vector_rotation #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    avr_vtx_if.sink   i_vtx,
    avr_rot_if.source o_rot
);

    localparam int NCS   = int'(avr_pkg::CORDIC_STEPS);
    localparam int NST   = NCS + 6;
    localparam int ST_CF = NCS + 1;
    localparam int XYW   = int'(avr_pkg::XY_W);
    localparam int ZW    = int'(avr_pkg::Z_W);
    localparam int CFW   = int'(avr_pkg::COEF_W);
    localparam int TW    = int'(avr_pkg::TURN_W);
    localparam int FRB   = int'(avr_pkg::FRAC_BITS);
    localparam int LO_W  = COORD_WIDTH / 2;
    localparam int HI_W  = COORD_WIDTH - LO_W;
    localparam int PH_W  = HI_W + CFW;
    localparam int PL_W  = LO_W + 1 + CFW;
    localparam int HS_W  = PH_W + 1;
    localparam int LS_W  = PL_W + 2;
    localparam int SUM_W = COORD_WIDTH + CFW + 3;
    localparam int T_W   = SUM_W - FRB;

    typedef logic signed [COORD_WIDTH-1:0] t_crd;

    // pipeline control: all stages advance together
    logic           w_ce;
    logic [NST-1:0] r_vld;

    assign w_ce        = !r_vld[NST-1] || o_rot.ready;
    assign i_vtx.ready = w_ce;
    assign o_rot.valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[NST-2:0], i_vtx.valid};
        end
    end

    // CORDIC stage registers, index 0 is the input stage
    avr_pkg::t_xy  r_cx   [0:NCS];
    avr_pkg::t_xy  r_cy   [0:NCS];
    avr_pkg::t_ang r_cz   [0:NCS];
    logic          r_flip [0:NCS];
    logic [1:0]    r_cmd  [0:NCS];
    t_crd          r_vx   [0:NCS];
    t_crd          r_vy   [0:NCS];
    t_crd          r_vz   [0:NCS];

    // input stage: left-align angle, fold into [-1/4, 1/4) turn
    logic [TW-1:0]  n_th;
    logic           n_flip;
    avr_pkg::t_ang  n_z0;

    always_comb begin
        n_th   = {i_vtx.angle, {(TW-ANGLE_WIDTH){1'b0}}};
        n_flip = n_th[TW-1] ^ n_th[TW-2];
        n_z0   = ZW'($signed({n_th[TW-1] ^ n_flip, n_th[TW-2:0]}));
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_cx[0]   <= XYW'(avr_pkg::CORDIC_GAIN_Q30);
            r_cy[0]   <= '0;
            r_cz[0]   <= n_z0;
            r_flip[0] <= n_flip;
            r_cmd[0]  <= i_vtx.command;
            r_vx[0]   <= i_vtx.x;
            r_vy[0]   <= i_vtx.y;
            r_vz[0]   <= i_vtx.z;
        end
    end

    // one micro-rotation per stage
    for (genvar gi = 0; gi < NCS; gi++) begin : g_cordic
        avr_pkg::t_xy  n_dx;
        avr_pkg::t_xy  n_dy;
        avr_pkg::t_ang n_at;

        always_comb begin
            n_dx = r_cy[gi] >>> gi;
            n_dy = r_cx[gi] >>> gi;
            n_at = ZW'(avr_pkg::atan_turn32(gi));
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                if (!r_cz[gi][ZW-1]) begin
                    r_cx[gi+1] <= r_cx[gi] - n_dx;
                    r_cy[gi+1] <= r_cy[gi] + n_dy;
                    r_cz[gi+1] <= r_cz[gi] - n_at;
                end else begin
                    r_cx[gi+1] <= r_cx[gi] + n_dx;
                    r_cy[gi+1] <= r_cy[gi] - n_dy;
                    r_cz[gi+1] <= r_cz[gi] + n_at;
                end
                r_flip[gi+1] <= r_flip[gi];
                r_cmd[gi+1]  <= r_cmd[gi];
                r_vx[gi+1]   <= r_vx[gi];
                r_vy[gi+1]   <= r_vy[gi];
                r_vz[gi+1]   <= r_vz[gi];
            end
        end
    end

    // coefficient stage: undo the fold, pick the rotated pair (p, q)
    avr_pkg::t_coef r_c, r_s, r_ns;
    t_crd           r_p, r_q;
    logic [1:0]     r_pcmd;
    t_crd           r_px, r_py, r_pz;
    avr_pkg::t_xy   n_cf, n_sf, n_nsf;
    t_crd           n_p, n_q;

    always_comb begin
        n_cf  = r_flip[NCS] ? -r_cx[NCS] : r_cx[NCS];
        n_sf  = r_flip[NCS] ? -r_cy[NCS] : r_cy[NCS];
        n_nsf = r_flip[NCS] ? r_cy[NCS] : -r_cy[NCS];
        case (r_cmd[NCS])
            avr_pkg::CMD_ROT_X: begin
                n_p = r_vy[NCS];
                n_q = r_vz[NCS];
            end
            avr_pkg::CMD_ROT_Y: begin
                n_p = r_vz[NCS];
                n_q = r_vx[NCS];
            end
            default: begin
                n_p = r_vx[NCS];
                n_q = r_vy[NCS];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_c    <= CFW'(n_cf);
            r_s    <= CFW'(n_sf);
            r_ns   <= CFW'(n_nsf);
            r_p    <= n_p;
            r_q    <= n_q;
            r_pcmd <= r_cmd[NCS];
            r_px   <= r_vx[NCS];
            r_py   <= r_vy[NCS];
            r_pz   <= r_vz[NCS];
        end
    end

    // partial products: coordinates split into signed high and unsigned low halves
    logic signed [HI_W-1:0] n_ph, n_qh;
    logic signed [LO_W:0]   n_pl, n_ql;
    logic signed [PH_W-1:0] r_pah, r_qah, r_pbh, r_qbh;
    logic signed [PL_W-1:0] r_pal, r_qal, r_pbl, r_qbl;
    logic [1:0]             r_mcmd;
    t_crd                   r_mx, r_my, r_mz;

    always_comb begin
        n_ph = $signed(r_p[COORD_WIDTH-1:LO_W]);
        n_qh = $signed(r_q[COORD_WIDTH-1:LO_W]);
        n_pl = $signed({1'b0, r_p[LO_W-1:0]});
        n_ql = $signed({1'b0, r_q[LO_W-1:0]});
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_pah  <= PH_W'(n_ph) * PH_W'(r_c);
            r_pal  <= PL_W'(n_pl) * PL_W'(r_c);
            r_qah  <= PH_W'(n_qh) * PH_W'(r_ns);
            r_qal  <= PL_W'(n_ql) * PL_W'(r_ns);
            r_pbh  <= PH_W'(n_ph) * PH_W'(r_s);
            r_pbl  <= PL_W'(n_pl) * PL_W'(r_s);
            r_qbh  <= PH_W'(n_qh) * PH_W'(r_c);
            r_qbl  <= PL_W'(n_ql) * PL_W'(r_c);
            r_mcmd <= r_pcmd;
            r_mx   <= r_px;
            r_my   <= r_py;
            r_mz   <= r_pz;
        end
    end

    // partial sums, rounding constant folded into the low sum
    localparam logic signed [LS_W-1:0] ROUND_HALF = LS_W'(1) <<< (FRB - 1);

    logic signed [HS_W-1:0] r_has, r_hbs;
    logic signed [LS_W-1:0] r_las, r_lbs;
    logic [1:0]             r_scmd;
    t_crd                   r_sx, r_sy, r_sz;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_has  <= HS_W'(r_pah) + HS_W'(r_qah);
            r_hbs  <= HS_W'(r_pbh) + HS_W'(r_qbh);
            r_las  <= LS_W'(r_pal) + LS_W'(r_qal) + ROUND_HALF;
            r_lbs  <= LS_W'(r_pbl) + LS_W'(r_qbl) + ROUND_HALF;
            r_scmd <= r_mcmd;
            r_sx   <= r_mx;
            r_sy   <= r_my;
            r_sz   <= r_mz;
        end
    end

    // full sum, floor shift by the fraction bits
    logic signed [SUM_W-1:0] n_suma, n_sumb;
    logic signed [T_W-1:0]   r_ta, r_tb;
    logic [1:0]              r_tcmd;
    t_crd                    r_tx, r_ty, r_tz;

    always_comb begin
        n_suma = (SUM_W'(r_has) <<< LO_W) + SUM_W'(r_las);
        n_sumb = (SUM_W'(r_hbs) <<< LO_W) + SUM_W'(r_lbs);
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ta   <= $signed(n_suma[SUM_W-1:FRB]);
            r_tb   <= $signed(n_sumb[SUM_W-1:FRB]);
            r_tcmd <= r_scmd;
            r_tx   <= r_sx;
            r_ty   <= r_sy;
            r_tz   <= r_sz;
        end
    end

    // clamp to the coordinate range
    function automatic t_crd sat_coord(input logic signed [T_W-1:0] t);
        logic [T_W-COORD_WIDTH:0] top;
        t_crd                     r;
        top = t[T_W-1:COORD_WIDTH-1];
        if (top == '0 || top == '1) begin
            r = t[COORD_WIDTH-1:0];
        end else if (t[T_W-1]) begin
            r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

    // output stage: place the rotated pair back on its axes
    t_crd r_ox, r_oy, r_oz;
    t_crd n_ra, n_rb, n_ox, n_oy, n_oz;

    always_comb begin
        n_ra = sat_coord(r_ta);
        n_rb = sat_coord(r_tb);
        case (r_tcmd)
            avr_pkg::CMD_ROT_X: begin
                n_ox = r_tx;
                n_oy = n_ra;
                n_oz = n_rb;
            end
            avr_pkg::CMD_ROT_Y: begin
                n_ox = n_rb;
                n_oy = r_ty;
                n_oz = n_ra;
            end
            avr_pkg::CMD_ROT_Z: begin
                n_ox = n_ra;
                n_oy = n_rb;
                n_oz = r_tz;
            end
            default: begin
                n_ox = r_tx;
                n_oy = r_ty;
                n_oz = r_tz;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ox <= n_ox;
            r_oy <= n_oy;
            r_oz <= n_oz;
        end
    end

    assign o_rot.out_x = r_ox;
    assign o_rot.out_y = r_oy;
    assign o_rot.out_z = r_oz;

    // checks on pipeline control and CORDIC output range
    localparam logic signed [CFW-1:0] COEF_BOUND = CFW'((64'd1 << FRB) + 64'd64);

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-1] && !o_rot.ready) |-> !i_vtx.ready)
        else $error("input accepted while output stalled");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ce |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    a_request_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ce && i_vtx.valid) |=> r_vld[0])
        else $error("accepted request lost at input stage");

    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_CF] |-> (r_c <= COEF_BOUND && r_c >= -COEF_BOUND
                          && r_s <= COEF_BOUND && r_s >= -COEF_BOUND))
        else $error("sine or cosine out of range");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the axis vector rotation block.
// Holds a bit-exact CORDIC rotation predictor and the stimulus, in one module.
// Depends on avr_pkg, the channel interfaces in avr_intf.sv and axis_vector_rotation.
`timescale 1ns / 1ps

module testbench;

    localparam int COORD_W = 32;
    localparam int ANGLE_W = 16;
    localparam int ROT_STEPS = 30;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam int PIPE_DEPTH = 36;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [1:0]          command;
        t_coord              x;
        t_coord              y;
        t_coord              z;
        logic [ANGLE_W-1:0]  angle;
    } t_vertex_req;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vertex_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    avr_vtx_if #(.COORD_WIDTH(COORD_W), .ANGLE_WIDTH(ANGLE_W)) vtx_bus ();
    avr_rot_if #(.COORD_WIDTH(COORD_W)) rot_bus ();

    axis_vector_rotation #(
        .COORD_WIDTH(COORD_W),
        .ANGLE_WIDTH(ANGLE_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_bus),
        .o_rot   (rot_bus)
    );

    // atan(2^-i) in 2^-32 turn units
    longint atan_step [0:ROT_STEPS-1] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    t_vertex_res pending_rotations [$];
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_left = 0;
    int mismatches = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int axis_hits [4] = '{0, 0, 0, 0};

    always #10 i_clk = ~i_clk;

    // sine and cosine of a binary angle, Q2.30, by 30 micro-rotations
    function automatic void rot_sincos(input logic [ANGLE_W-1:0] ang,
                                       output longint cos_q30, output longint sin_q30);
        logic [31:0] theta;
        logic [31:0] probe;
        logic        flip;
        longint      resid;
        longint      cx;
        longint      cy;
        longint      dx;
        longint      dy;
        theta = 32'(ang) << (32 - ANGLE_W);
        // second and third quadrant: rotate by half a turn less, negate after
        probe = theta + 32'h4000_0000;
        flip = probe[31];
        if (flip)
            theta = theta - 32'h8000_0000;
        resid = longint'($signed(theta));
        cx = GAIN_Q30;
        cy = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (resid >= 0) begin
                cx = cx - dx;
                cy = cy + dy;
                resid = resid - atan_step[i];
            end else begin
                cx = cx + dx;
                cy = cy - dy;
                resid = resid + atan_step[i];
            end
        end
        cos_q30 = flip ? -cx : cx;
        sin_q30 = flip ? -cy : cy;
    endfunction

    // (p*k1 + q*k2) in Q2.30, rounded half up, saturated to the coordinate range
    function automatic longint rot_mix(input longint p, input longint k1,
                                       input longint q, input longint k2);
        longint acc;
        acc = p * k1 + q * k2 + (longint'(1) <<< 29);
        acc = acc >>> 30;
        if (acc > COORD_MAX)
            acc = COORD_MAX;
        if (acc < COORD_MIN)
            acc = COORD_MIN;
        return acc;
    endfunction

    function automatic t_vertex_res rotate_vertex(input t_vertex_req req);
        longint      v [3];
        longint      r [3];
        longint      c;
        longint      s;
        int          a;
        int          b;
        t_vertex_res res;
        v[0] = longint'(req.x);
        v[1] = longint'(req.y);
        v[2] = longint'(req.z);
        r = v;
        if (req.command != avr_pkg::CMD_PASS) begin
            // rotated pair: (y,z) for X, (z,x) for Y, (x,y) for Z
            a = (int'(req.command) + 1) % 3;
            b = (int'(req.command) + 2) % 3;
            rot_sincos(req.angle, c, s);
            r[a] = rot_mix(v[a], c, v[b], -s);
            r[b] = rot_mix(v[a], s, v[b], c);
        end
        res.x = t_coord'(r[0]);
        res.y = t_coord'(r[1]);
        res.z = t_coord'(r[2]);
        return res;
    endfunction

    // one request: optional idle cycles, then hold valid until taken
    task automatic send_vertex(input t_vertex_req req);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            vtx_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        vtx_bus.valid   <= 1'b1;
        vtx_bus.command <= req.command;
        vtx_bus.x       <= req.x;
        vtx_bus.y       <= req.y;
        vtx_bus.z       <= req.z;
        vtx_bus.angle   <= req.angle;
        @(posedge i_clk);
        while (!vtx_bus.ready)
            @(posedge i_clk);
        pending_rotations.push_back(rotate_vertex(req));
        requests_sent++;
        axis_hits[req.command]++;
    endtask

    task automatic release_valid();
        @(negedge i_clk);
        vtx_bus.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_rotations.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_vertex_req make_vertex(input logic [1:0] cmd, input t_coord x,
                                                input t_coord y, input t_coord z,
                                                input logic [ANGLE_W-1:0] ang);
        t_vertex_req req;
        req.command = cmd;
        req.x = x;
        req.y = y;
        req.z = z;
        req.angle = ang;
        return req;
    endfunction

    function automatic t_coord rand_coord();
        t_coord c;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: c = t_coord'(COORD_MAX);
                    1: c = t_coord'(COORD_MIN);
                    2: c = '0;
                    3: c = '1;
                    default: c = 32'sd1;
                endcase
            end
            1, 2: c = t_coord'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
            default: c = t_coord'($urandom);
        endcase
        return c;
    endfunction

    function automatic t_vertex_req rand_vertex();
        t_vertex_req req;
        req.command = ($urandom_range(9) == 0) ? avr_pkg::CMD_PASS : 2'($urandom_range(2));
        req.x = rand_coord();
        req.y = rand_coord();
        req.z = rand_coord();
        // now and then hug a quadrant boundary
        if ($urandom_range(7) == 0)
            req.angle = ANGLE_W'(($urandom_range(3) << (ANGLE_W - 2)) + $urandom_range(4) - 2);
        else
            req.angle = ANGLE_W'($urandom_range(2 ** ANGLE_W - 1));
        return req;
    endfunction

    // identity, quarter turns, quadrant edges, saturation, pass-through
    task automatic test_directed_corners();
        t_coord one_0;
        t_coord two_0;
        t_coord three_0;
        t_coord cmax;
        t_coord cmin;
        one_0 = 32'sh0001_0000;
        two_0 = 32'sh0002_0000;
        three_0 = 32'sh0003_0000;
        cmax = t_coord'(COORD_MAX);
        cmin = t_coord'(COORD_MIN);
        send_vertex(make_vertex(avr_pkg::CMD_ROT_X, one_0, two_0, three_0, 16'd0));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_Y, one_0, two_0, three_0, 16'd16384));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_Z, one_0, two_0, three_0, 16'd32768));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_X, one_0, two_0, three_0, 16'd49152));
        send_vertex(make_vertex(avr_pkg::CMD_PASS, cmax, cmin, '1, 16'd12345));
        send_vertex(make_vertex(avr_pkg::CMD_PASS, 32'sh1234_5678, 32'sh0,
                                32'sh7FFF_0001, 16'hFFFF));
        // 45 degrees on the diagonal overflows both ways
        send_vertex(make_vertex(avr_pkg::CMD_ROT_Z, cmax, cmax, 32'sd0, 16'd8192));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_Z, cmin, cmin, 32'sd0, 16'd8192));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_X, 32'sd0, cmin, cmax, 16'hFFFF));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_Y, cmin, 32'sd0, cmin, 16'd24576));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_Y, cmax, cmin, cmax, 16'd40960));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_Z, cmax, cmin, 32'sd1, 16'd16383));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_Z, cmax, cmin, 32'sd1, 16'd16384));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_Y, cmin, cmax, '1, 16'd49151));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_Y, cmin, cmax, '1, 16'd49152));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_X, cmin, cmax, 32'sd5, 16'd32767));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_Z, 32'sd0, 32'sd0, 32'sd0, 16'hFFFF));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_X, '1, '1, '1, 16'd1));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_Z, 32'sh0000_8000, one_0, 32'sd0,
                                16'd21845));
        send_vertex(make_vertex(avr_pkg::CMD_ROT_Y, 32'sd1, 32'sd1, 32'sd1, 16'd8191));
        release_valid();
        wait_drained();
    endtask

    task automatic test_random_stream(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++)
            send_vertex(rand_vertex());
        release_valid();
    endtask

    // long receiver stall while requests keep coming, then drain before resuming
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_left = 200;
        for (int n = 0; n < 90; n++)
            send_vertex(rand_vertex());
        release_valid();
        wait_drained();
        for (int n = 0; n < 30; n++)
            send_vertex(rand_vertex());
        release_valid();
    endtask

    // output ready: long hold-off first, otherwise random idling
    initial begin
        rot_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                rot_bus.ready <= 1'b0;
                rx_hold_left--;
            end else begin
                rot_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic check_field(input string name, input t_coord want, input t_coord got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %h got %h", $realtime, name, want, got);
        end
    endtask

    // compare each rotated vertex with the oldest request still in flight
    always @(posedge i_clk) begin : result_check
        t_vertex_res want;
        if (i_rst_n && rot_bus.valid && rot_bus.ready) begin
            if (pending_rotations.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %h %h %h with no request pending", $realtime,
                             rot_bus.out_x, rot_bus.out_y, rot_bus.out_z);
            end else begin
                want = pending_rotations.pop_front();
                check_field("out_x", want.x, rot_bus.out_x);
                check_field("out_y", want.y, rot_bus.out_y);
                check_field("out_z", want.z, rot_bus.out_z);
                results_checked++;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_rotations.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        vtx_bus.valid   = 1'b0;
        vtx_bus.command = avr_pkg::CMD_ROT_X;
        vtx_bus.x       = '0;
        vtx_bus.y       = '0;
        vtx_bus.z       = '0;
        vtx_bus.angle   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_corners();
        test_random_stream(400, 24, 80);
        test_random_stream(400, 80, 24);
        test_output_backpressure();
        test_random_stream(400, 0, 0);

        wait_drained();
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        if (pending_rotations.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", pending_rotations.size());
        end

        $display("Rotated %0d vertices (X %0d, Y %0d, Z %0d, pass-through %0d), %0d checked.",
                 requests_sent, axis_hits[avr_pkg::CMD_ROT_X], axis_hits[avr_pkg::CMD_ROT_Y],
                 axis_hits[avr_pkg::CMD_ROT_Z], axis_hits[avr_pkg::CMD_PASS], results_checked);
        $display("Covered quadrant edges, saturation, idling both ways, long stall; %0d errors.",
                 mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
src/avr_pkg.sv
src/avr_intf.sv
src/axis_vector_rotation.sv
test/testbench.sv
